@@ hdl/cpd_pkg.sv @@
package cpd_pkg;

   // Default store dimensions.
   localparam int MaxWidthDefault  = 1024;
   localparam int MaxHeightDefault = 1024;

   // Store entry: lit flag over a 9-bit level, where FreshLevel marks a new plot.
   localparam int EntryW            = 10;
   localparam int LevelW            = 9;
   localparam logic [8:0] FreshLevel = 9'd256;

   // Wide enough to hold a clamped window dimension up to 4096.
   localparam int DimW = 13;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 12;

   localparam logic [CsrIdxW-1:0] RegLevelCount   = 3'd0;
   localparam logic [CsrIdxW-1:0] RegWindowWidth  = 3'd1;
   localparam logic [CsrIdxW-1:0] RegWindowHeight = 3'd2;
   localparam logic [CsrIdxW-1:0] RegOffsetX      = 3'd3;
   localparam logic [CsrIdxW-1:0] RegOffsetY      = 3'd4;

   localparam logic [1:0] FuncPlot    = 2'd0;
   localparam logic [1:0] FuncTick    = 2'd1;
   localparam logic [1:0] FuncRefresh = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [11:0] coord_x;
      logic signed [11:0] coord_y;
      logic               refresh_last;
   } req_type;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  level;
      logic        went_dark;
   } rsp_type;

   typedef struct packed {
      logic clear_wr;
      logic latch_item;
      logic mem_rd;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic has_result;
      logic out_busy;
   } status_type;

endpackage

@@ hdl/crt_phosphor_decay_store.sv @@
// Phosphor decay store for a point-plotting CRT.
// Items arrive on the req_ channel (valid/ready): a plot marks a pixel freshly
// lit, a frame tick bumps the saturating decay count, and a refresh reads one
// pixel, ages it and reports it on the rsp_ channel (valid/ready) if it was lit.
// Configuration registers are written through csr_wr_en/csr_index/csr_wdata
// and take effect on the next item; they should change only while idle.
// Each item passes through the transfer, a pixel memory read, and the
// read-modify-write of the entry. No new item is taken before that commits.
// A refresh result is loaded, and rsp_valid raised, when its update commits.
// The result register lets the next item be accepted while a result waits;
// only a refresh that yields a new result while the old one is still stalled
// holds in its update step until rsp_ready frees the register.
// After reset the block sweeps all MAX_WIDTH * MAX_HEIGHT pixel memory entries
// to unlit, one entry a cycle, with req_ready low. Configuration writes
// are taken during the sweep.
module crt_phosphor_decay_store #(
   parameter int MAX_WIDTH  = cpd_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = cpd_pkg::MaxHeightDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cpd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cpd_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [cpd_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [cpd_pkg::CsrDataW-1:0]  csr_wdata
);

   cpd_pkg::cmd_type    cmd;
   cpd_pkg::status_type status;

   cpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpd_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

@@ hdl/cpd_ctrl.sv @@
module cpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cpd_pkg::status_type status,
   output cpd_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MODIFY
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      stall;

   // A refresh result cannot be loaded while the previous one is still held.
   assign stall = status.has_result & status.out_busy;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               state_in = ST_READ;
               ready_in = 1'b0;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (!stall) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready      = ready_ff;
   assign cmd.clear_wr   = (state_ff == ST_CLEAR);
   assign cmd.latch_item = (state_ff == ST_IDLE) & req_valid & ready_ff;
   assign cmd.mem_rd     = (state_ff == ST_READ);
   assign cmd.commit     = (state_ff == ST_MODIFY) & ~stall;

endmodule

@@ hdl/cpd_datapath.sv @@
module cpd_datapath #(
   parameter int MAX_WIDTH  = cpd_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = cpd_pkg::MaxHeightDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cpd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cpd_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [cpd_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [cpd_pkg::CsrDataW-1:0]    csr_wdata,
   input  cpd_pkg::cmd_type                cmd,
   output cpd_pkg::status_type             status
);

   localparam int Depth     = MAX_WIDTH * MAX_HEIGHT;
   localparam int AddrW     = $clog2(Depth);
   localparam int LastEntry = Depth - 1;
   localparam int DimW      = cpd_pkg::DimW;
   localparam int LevelW    = cpd_pkg::LevelW;
   localparam int EntryW    = cpd_pkg::EntryW;

   // Configuration registers.
   logic [8:0]  level_count_ff;
   logic [10:0] window_width_ff;
   logic [10:0] window_height_ff;
   logic [11:0] offset_x_ff;
   logic [11:0] offset_y_ff;

   logic [15:0]          decay_ff, decay_in;
   logic [AddrW-1:0]     clr_cnt_ff;
   cpd_pkg::req_type     item_ff;
   logic [EntryW-1:0]    rd_ff;
   logic                 rsp_valid_ff;
   cpd_pkg::rsp_type     rsp_ff, rsp_in;

   logic [EntryW-1:0]    mem [Depth];

   logic [8:0]           lc;
   logic [DimW-1:0]      win_w, win_h;
   logic                 is_plot, is_refresh, is_tick;
   logic [10:0]          plot_x, plot_y;
   logic                 plot_ok, refresh_ok;
   logic [10:0]          col;
   logic [DimW-1:0]      row;
   logic [AddrW-1:0]     addr;
   logic [LevelW-1:0]    old_lv, new_lv;
   logic                 dark;
   logic                 has_result;
   logic                 mem_wr;
   logic [AddrW-1:0]     wr_addr;
   logic [EntryW-1:0]    wr_data;

   // Clamp the level count and window registers to their legal ranges.
   always_comb begin
      if (level_count_ff < 9'd2) begin
         lc = 9'd2;
      end else if (level_count_ff > 9'd256) begin
         lc = 9'd256;
      end else begin
         lc = level_count_ff;
      end
      if (window_width_ff == 11'd0) begin
         win_w = DimW'(1);
      end else if (DimW'(window_width_ff) > DimW'(MAX_WIDTH)) begin
         win_w = DimW'(MAX_WIDTH);
      end else begin
         win_w = DimW'(window_width_ff);
      end
      if (window_height_ff == 11'd0) begin
         win_h = DimW'(1);
      end else if (DimW'(window_height_ff) > DimW'(MAX_HEIGHT)) begin
         win_h = DimW'(MAX_HEIGHT);
      end else begin
         win_h = DimW'(window_height_ff);
      end
   end

   assign is_plot    = (item_ff.func == cpd_pkg::FuncPlot);
   assign is_tick    = (item_ff.func == cpd_pkg::FuncTick);
   assign is_refresh = (item_ff.func == cpd_pkg::FuncRefresh);

   // Plots clamp negative coordinates to zero; refreshes reject them.
   assign plot_x = item_ff.coord_x[11] ? 11'd0 : item_ff.coord_x[10:0];
   assign plot_y = item_ff.coord_y[11] ? 11'd0 : item_ff.coord_y[10:0];

   assign plot_ok = (DimW'(plot_x) < win_w) && (DimW'(plot_y) < win_h);
   assign refresh_ok = !item_ff.coord_x[11] && !item_ff.coord_y[11] &&
                       (DimW'(item_ff.coord_x[10:0]) < win_w) &&
                       (DimW'(item_ff.coord_y[10:0]) < win_h);

   // Plot y counts bottom-up, so it is flipped into a top-down row.
   assign col = is_plot ? plot_x : item_ff.coord_x[10:0];
   assign row = is_plot ? (win_h - DimW'(1) - DimW'(plot_y))
                        : DimW'(item_ff.coord_y[10:0]);
   assign addr = AddrW'(row) * AddrW'(MAX_WIDTH) + AddrW'(col);

   // Decay of the entry read for a refresh.
   assign old_lv = rd_ff[LevelW-1:0];
   always_comb begin
      if (old_lv == cpd_pkg::FreshLevel) begin
         new_lv = lc - 9'd1;
      end else if ({7'd0, old_lv} > decay_ff) begin
         new_lv = old_lv - decay_ff[LevelW-1:0];
      end else begin
         new_lv = '0;
      end
   end
   assign dark       = (new_lv == '0);
   assign has_result = is_refresh & refresh_ok & rd_ff[EntryW-1];

   always_comb begin
      rsp_in.pixel_x   = 12'(col) + offset_x_ff;
      rsp_in.pixel_y   = 12'(row) + offset_y_ff;
      rsp_in.level     = new_lv[7:0];
      rsp_in.went_dark = dark;
   end

   always_comb begin
      decay_in = decay_ff;
      if (is_tick && decay_ff != 16'hFFFF) begin
         decay_in = decay_ff + 16'd1;
      end else if (is_refresh && item_ff.refresh_last) begin
         decay_in = '0;
      end
   end

   always_comb begin
      mem_wr  = 1'b0;
      wr_addr = addr;
      wr_data = {1'b1, cpd_pkg::FreshLevel};
      if (cmd.clear_wr) begin
         mem_wr  = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cmd.commit && is_plot && plot_ok) begin
         mem_wr = 1'b1;
      end else if (cmd.commit && has_result) begin
         mem_wr  = 1'b1;
         wr_data = dark ? '0 : {1'b1, new_lv};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         item_ff <= req_data;
      end
      if (cmd.commit && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff   <= 9'd8;
         window_width_ff  <= 11'd1024;
         window_height_ff <= 11'd1024;
         offset_x_ff      <= '0;
         offset_y_ff      <= '0;
         decay_ff         <= '0;
         clr_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               cpd_pkg::RegLevelCount:   level_count_ff   <= csr_wdata[8:0];
               cpd_pkg::RegWindowWidth:  window_width_ff  <= csr_wdata[10:0];
               cpd_pkg::RegWindowHeight: window_height_ff <= csr_wdata[10:0];
               cpd_pkg::RegOffsetX:      offset_x_ff      <= csr_wdata;
               cpd_pkg::RegOffsetY:      offset_y_ff      <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.commit) begin
            decay_ff <= decay_in;
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + AddrW'(1);
         end
         if (cmd.commit && has_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_last = (clr_cnt_ff == AddrW'(LastEntry));
   assign status.has_result = has_result;
   assign status.out_busy   = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
